/* hdl/mcofifo_pkg.sv */
// Package for the multichannel overwrite FIFO: field widths, reset values,
// parameter defaults and the action codes. No dependencies.
package mcofifo_pkg;

    localparam int ACTION_W = 2;
    localparam int CHAN_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int DEPTH_W  = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    localparam int CHAN_COUNT_DEF = 4;
    localparam int MAX_DEPTH_DEF  = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_ADVANCE = 2'd2
    } t_action;

endpackage

/* hdl/mcofifo_if.sv */
// Valid/ready channel interfaces for the multichannel overwrite FIFO.
// Depends on mcofifo_pkg for the payload widths.
interface mcofifo_in_if;
    import mcofifo_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAN_W-1:0]   channel;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, output action, output channel, output data_byte,
                    input ready);
    modport sink   (input valid, input action, input channel, input data_byte,
                    output ready);
endinterface

interface mcofifo_out_if;
    import mcofifo_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic              read_hit;
    logic              overflow_seen;
    logic [CHAN_W-1:0] current_chan;

    modport source (output valid, output read_byte, output read_hit,
                    output overflow_seen, output current_chan, input ready);
    modport sink   (input valid, input read_byte, input read_hit,
                    input overflow_seen, input current_chan, output ready);
endinterface

/* hdl/multichannel_overwrite_fifo.sv */
// Top level of the multichannel overwrite FIFO: per-channel byte rings in one
// shared memory. Depends on mcofifo_pkg and the interfaces in mcofifo_if.sv.
//
//   Port          Direction  Handshake      Carries
//   i_in          sink       valid/ready    action, channel, data_byte
//   o_out         source     valid/ready    read_byte, read_hit, overflow_seen,
//                                           current_chan
//   i_cfg_*       input      write enable   depth_in_use (no read-back)
//
// One word is accepted per cycle while the result side keeps taking results. A word
// waits in the input register and moves to the result register once that is free or
// being emptied; the synchronous read port of the byte memory sits between those two
// registers.
// Reset is synchronous and active low. It clears the ring pointers, the fill
// counts, the overflow flag and the round-robin counter; the byte memory is not
// cleared, since a read only reaches bytes that a write has stored.
// When the result is not taken, the input register holds and input ready drops.
module multichannel_overwrite_fifo #(
    parameter int CHAN_COUNT = mcofifo_pkg::CHAN_COUNT_DEF,
    parameter int MAX_DEPTH  = mcofifo_pkg::MAX_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mcofifo_pkg::DEPTH_W-1:0]  i_cfg_wdata,
    mcofifo_in_if.sink                       i_in,
    mcofifo_out_if.source                    o_out
);
    import mcofifo_pkg::*;

    // Channel index, ring slot, fill count and memory address widths.
    localparam int CHW     = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam int SW      = $clog2(MAX_DEPTH);
    localparam int FW      = $clog2(MAX_DEPTH + 1);
    localparam int LW      = (FW > DEPTH_W) ? FW : DEPTH_W;
    localparam int ENTRIES = CHAN_COUNT * MAX_DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Advance a ring slot, wrapping at the physical ring size.
    function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] slot);
        logic [SW:0] sum;
        sum = {1'b0, slot} + (SW+1)'(1);
        return (sum >= (SW+1)'(MAX_DEPTH)) ? '0 : sum[SW-1:0];
    endfunction

    // Configuration register.
    logic [DEPTH_W-1:0] r_depth;

    // Input register.
    logic                r_a_valid;
    logic [ACTION_W-1:0] r_a_action;
    logic [CHAN_W-1:0]   r_a_chan;
    logic [BYTE_W-1:0]   r_a_data;

    // Result register. Overflow and current channel are read straight from the
    // state registers: they only change when a word moves into this stage.
    logic                r_b_valid;
    logic                r_b_hit;
    logic [BYTE_W-1:0]   r_mem_q;

    // Per-channel ring state and global flags.
    logic [SW-1:0]       r_wslot [CHAN_COUNT];
    logic [SW-1:0]       r_rslot [CHAN_COUNT];
    logic [FW-1:0]       r_fill  [CHAN_COUNT];
    logic                r_ovf;
    logic [CHW-1:0]      r_rr;

    // Byte store shared by all channels; channel c owns a block of MAX_DEPTH.
    logic [BYTE_W-1:0]   r_mem [ENTRIES];

    logic                adv;
    logic                chan_ok;
    logic [CHW-1:0]      ch;
    logic [SW-1:0]       cur_w;
    logic [SW-1:0]       cur_r;
    logic [FW-1:0]       cur_f;
    logic [LW-1:0]       limit;
    logic                full;
    logic                do_wr;
    logic                do_rd;
    logic                do_adv;
    logic [SW-1:0]       n_wslot;
    logic [SW-1:0]       n_rslot;
    logic [FW-1:0]       n_fill;
    logic                n_ovf;
    logic [CHW-1:0]      n_rr;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    // The input register moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign adv        = r_a_valid && (!r_b_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || adv;

    assign chan_ok = (int'(r_a_chan) < CHAN_COUNT);
    assign ch      = CHW'(r_a_chan);
    assign cur_w   = r_wslot[ch];
    assign cur_r   = r_rslot[ch];
    assign cur_f   = r_fill[ch];

    // A depth of zero behaves as one; anything above the ring size as the ring size.
    always_comb begin
        limit = LW'(r_depth);
        if (limit == '0) begin
            limit = LW'(1);
        end else if (limit > LW'(MAX_DEPTH)) begin
            limit = LW'(MAX_DEPTH);
        end
    end

    assign full = (LW'(cur_f) >= limit);

    always_comb begin
        do_wr  = 1'b0;
        do_rd  = 1'b0;
        do_adv = 1'b0;
        unique case (r_a_action)
            ACT_WRITE:   do_wr  = adv && chan_ok;
            ACT_READ:    do_rd  = adv && chan_ok && (cur_f != '0);
            ACT_ADVANCE: do_adv = adv;
            default:     ;
        endcase
    end

    // Next values for the addressed channel. A write into a full channel drops
    // the oldest byte by stepping the read slot, so the fill holds.
    always_comb begin
        n_wslot = cur_w;
        n_rslot = cur_r;
        n_fill  = cur_f;
        n_ovf   = r_ovf;
        if (do_wr) begin
            n_wslot = ring_next(cur_w);
            if (full) begin
                n_rslot = ring_next(cur_r);
                n_ovf   = 1'b1;
            end else begin
                n_fill = cur_f + FW'(1);
            end
        end else if (do_rd) begin
            n_rslot = ring_next(cur_r);
            n_fill  = cur_f - FW'(1);
        end
    end

    always_comb begin
        n_rr = r_rr;
        if (do_adv) begin
            n_rr = (int'(r_rr) + 1 >= CHAN_COUNT) ? '0 : r_rr + CHW'(1);
        end
    end

    assign wr_addr = AW'(int'(ch) * MAX_DEPTH + int'(cur_w));
    assign rd_addr = AW'(int'(ch) * MAX_DEPTH + int'(cur_r));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
        end else if (i_cfg_we) begin
            r_depth <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_action <= i_in.action;
            r_a_chan   <= i_in.channel;
            r_a_data   <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_hit   <= 1'b0;
        end else if (adv) begin
            r_b_valid <= 1'b1;
            r_b_hit   <= do_rd;
        end else if (o_out.ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                r_wslot[i] <= '0;
                r_rslot[i] <= '0;
                r_fill[i]  <= '0;
            end
            r_ovf <= 1'b0;
            r_rr  <= '0;
        end else begin
            if (adv && chan_ok) begin
                r_wslot[ch] <= n_wslot;
                r_rslot[ch] <= n_rslot;
                r_fill[ch]  <= n_fill;
            end
            r_ovf <= n_ovf;
            r_rr  <= n_rr;
        end
    end

    // Byte memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[wr_addr] <= r_a_data;
        end
        if (do_rd) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    assign o_out.valid         = r_b_valid;
    assign o_out.read_hit      = r_b_hit;
    assign o_out.read_byte     = r_b_hit ? r_mem_q : '0;
    assign o_out.overflow_seen = r_ovf;
    assign o_out.current_chan  = CHAN_W'(r_rr);

    // The distance between the write and read slots must agree with the fill
    // count of every channel.
    for (genvar g = 0; g < CHAN_COUNT; g++) begin : g_chk
        logic [SW:0] occ;
        always_comb begin
            if (r_wslot[g] >= r_rslot[g]) begin
                occ = {1'b0, r_wslot[g]} - {1'b0, r_rslot[g]};
            end else begin
                occ = {1'b0, r_wslot[g]} + (SW+1)'(MAX_DEPTH) - {1'b0, r_rslot[g]};
            end
        end

        a_fill_matches_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_fill[g] <= FW'(MAX_DEPTH)) &&
            (occ == ((r_fill[g] == FW'(MAX_DEPTH)) ? '0 : (SW+1)'(r_fill[g]))))
            else $error("fill count disagrees with ring slots");
    end

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_overflow_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(do_wr && full))
        else $error("overflow flag set by something other than a full write");

    a_rr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_rr) < CHAN_COUNT)
        else $error("round-robin channel out of range");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for multichannel_overwrite_fifo: a directed stimulus table, then
// random phases. Depends on mcofifo_pkg and the channel interfaces in mcofifo_if.sv.
module tb_top;
    import mcofifo_pkg::*;

    localparam int NUM_CH          = CHAN_COUNT_DEF;
    localparam int RING_DEPTH      = MAX_DEPTH_DEF;
    localparam int PTR_W           = $clog2(RING_DEPTH);
    localparam int LONG_HOLD       = 80;    // cycles the result side holds off once
    localparam int WATCHDOG_LIMIT  = 1000;  // cycles without any handshake
    localparam int PHASES          = 16;
    localparam int WORDS_PER_PHASE = 102;

    // The package leaves action code 3 unnamed. The block must treat it as a no-op.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One result word, field for field as the output channel carries it.
    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_hit;
        logic              overflow_seen;
        logic [CHAN_W-1:0] current_chan;
    } t_result;

    // A row of the directed table either sends one word or rewrites the depth register.
    // Where pinned is set, the result is typed into the row and checked as written.
    typedef enum logic { ROW_WORD, ROW_DEPTH } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   channel;
        logic [BYTE_W-1:0]   data_byte;
        logic [DEPTH_W-1:0]  depth;
        logic                pinned;
        t_result             result;
    } t_dir_row;

    // The directed part. It covers an empty read after reset, the counter wrap, the unused
    // action, byte extremes, depth 0 acting as 1 (with overflow), depth 31 acting as the
    // maximum, and depth lowered below the fill of a channel, which then drains normally.
    localparam t_dir_row DIR_ROWS [25] = '{
        '{ROW_WORD,  ACT_READ,    2'd0, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd0}},
        '{ROW_WORD,  ACT_ADVANCE, 2'd0, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd1}},
        '{ROW_WORD,  ACT_UNUSED,  2'd3, 8'hFF, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd1}},
        '{ROW_WORD,  ACT_ADVANCE, 2'd1, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd2}},
        '{ROW_WORD,  ACT_ADVANCE, 2'd2, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd3}},
        '{ROW_WORD,  ACT_ADVANCE, 2'd3, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd0}},
        '{ROW_WORD,  ACT_WRITE,   2'd3, 8'hFF, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd0}},
        '{ROW_WORD,  ACT_WRITE,   2'd3, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd0}},
        '{ROW_WORD,  ACT_READ,    2'd3, 8'h00, 5'd0,  1'b1, '{8'hFF, 1'b1, 1'b0, 2'd0}},
        '{ROW_DEPTH, ACT_WRITE,   2'd0, 8'h00, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_WRITE,   2'd1, 8'h5A, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 2'd0}},
        '{ROW_WORD,  ACT_WRITE,   2'd1, 8'hA5, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
        '{ROW_WORD,  ACT_READ,    2'd1, 8'h00, 5'd0,  1'b1, '{8'hA5, 1'b1, 1'b1, 2'd0}},
        '{ROW_WORD,  ACT_READ,    2'd1, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 2'd0}},
        '{ROW_DEPTH, ACT_WRITE,   2'd0, 8'h00, 5'd31, 1'b0, '0},
        '{ROW_WORD,  ACT_WRITE,   2'd2, 8'h11, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_WRITE,   2'd2, 8'h22, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_WRITE,   2'd2, 8'h33, 5'd0,  1'b0, '0},
        '{ROW_DEPTH, ACT_WRITE,   2'd0, 8'h00, 5'd1,  1'b0, '0},
        '{ROW_WORD,  ACT_WRITE,   2'd2, 8'h44, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_READ,    2'd2, 8'h00, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_READ,    2'd2, 8'h00, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_READ,    2'd2, 8'h00, 5'd0,  1'b0, '0},
        '{ROW_WORD,  ACT_READ,    2'd3, 8'h00, 5'd0,  1'b0, '0},
        '{ROW_DEPTH, ACT_WRITE,   2'd0, 8'h00, 5'd16, 1'b0, '0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [DEPTH_W-1:0]  i_cfg_wdata;

    mcofifo_in_if  in_ch ();
    mcofifo_out_if out_ch ();

    multichannel_overwrite_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state: a private copy of the rings, their pointers and fill counts, the
    // sticky overflow flag, the round-robin counter and the depth register.
    logic [BYTE_W-1:0]  ring_mem [NUM_CH][RING_DEPTH];
    logic [PTR_W-1:0]   wr_ptr   [NUM_CH];
    logic [PTR_W-1:0]   rd_ptr   [NUM_CH];
    logic [DEPTH_W-1:0] fill     [NUM_CH];
    logic               ovf_flag;
    logic [CHAN_W-1:0]  rr_chan;
    logic [DEPTH_W-1:0] depth_reg;

    t_result pending_results [$];   // results of accepted words, oldest first
    int      mismatch_count;
    bit      gaps_on;                // both sides idle at random while this is set
    bit      hold_req;               // asks the result side for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Applies one accepted word to the predictor state and returns the result it gives.
    function automatic t_result next_fifo_result(input logic [ACTION_W-1:0] act,
                                                 input logic [CHAN_W-1:0]   ch,
                                                 input logic [BYTE_W-1:0]   data);
        t_result            res;
        logic [DEPTH_W-1:0] cap;
        int                 c;
        res = '0;
        c   = int'(ch);
        // Depth 0 behaves as 1 and anything above the ring size behaves as the ring size.
        if (depth_reg == '0)
            cap = DEPTH_W'(1);
        else if (depth_reg > DEPTH_W'(RING_DEPTH))
            cap = DEPTH_W'(RING_DEPTH);
        else
            cap = depth_reg;
        case (act)
            ACT_WRITE: begin
                if (c < NUM_CH) begin
                    // A full channel (or one filled past a lowered depth) drops its oldest
                    // byte first, so the fill never grows beyond where it stood.
                    if (fill[c] >= cap) begin
                        ovf_flag  = 1'b1;
                        rd_ptr[c] = ring_advance(rd_ptr[c]);
                        fill[c]   = fill[c] - 1'b1;
                    end
                    ring_mem[c][wr_ptr[c]] = data;
                    wr_ptr[c] = ring_advance(wr_ptr[c]);
                    fill[c]   = fill[c] + 1'b1;
                end
            end
            ACT_READ: begin
                if (c < NUM_CH && fill[c] != '0) begin
                    res.read_byte = ring_mem[c][rd_ptr[c]];
                    res.read_hit  = 1'b1;
                    rd_ptr[c]     = ring_advance(rd_ptr[c]);
                    fill[c]       = fill[c] - 1'b1;
                end
            end
            ACT_ADVANCE: begin
                rr_chan = (rr_chan == CHAN_W'(NUM_CH - 1)) ? '0 : rr_chan + 1'b1;
            end
            default: begin
            end
        endcase
        res.overflow_seen = ovf_flag;
        res.current_chan  = rr_chan;
        return res;
    endfunction

    // Idle stretch in cycles: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Offers one word after an optional gap and waits for the block to take it. It returns
    // in the time step of the accepting edge with valid still high, so a back-to-back word
    // only updates the payload. The expectation is queued at acceptance, which keeps the
    // predictor in the order the block sees the words.
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [CHAN_W-1:0] ch,
                             input logic [BYTE_W-1:0] data, input logic pinned,
                             input t_result pinned_res);
        int      gap;
        t_result predicted;
        gap = idle_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.channel   <= ch;
        in_ch.data_byte <= data;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
        predicted = next_fifo_result(act, ch, data);
        pending_results.push_back(pinned ? pinned_res : predicted);
    endtask

    // The depth register is only rewritten once the block has drained: every word gives a
    // result, so an empty expectation queue means nothing is in flight. The spare cycles
    // cover the input and result registers anyway.
    task automatic write_depth(input logic [DEPTH_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        depth_reg = value;
        i_cfg_we <= 1'b0;
    endtask

    // Result side: ready stalls at random, with one long hold-off on request so the block
    // fills up and has to push back on its input while the sender keeps offering.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    // Every result word taken is compared field by field with the oldest expectation.
    // Values are read right after the edge, before any of that edge's updates land.
    initial begin : result_check
        t_result got;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_ch.read_byte, out_ch.read_hit, out_ch.overflow_seen,
                        out_ch.current_chan};
                if (pending_results.size() == 0) begin
                    $error("unexpected result word: read_byte %02h read_hit %0b",
                           got.read_byte, got.read_hit);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_byte !== want.read_byte) begin
                        $error("read_byte mismatch: expected %02h, actual %02h",
                               want.read_byte, got.read_byte);
                        mismatch_count++;
                    end
                    if (got.read_hit !== want.read_hit) begin
                        $error("read_hit mismatch: expected %0b, actual %0b",
                               want.read_hit, got.read_hit);
                        mismatch_count++;
                    end
                    if (got.overflow_seen !== want.overflow_seen) begin
                        $error("overflow_seen mismatch: expected %0b, actual %0b",
                               want.overflow_seen, got.overflow_seen);
                        mismatch_count++;
                    end
                    if (got.current_chan !== want.current_chan) begin
                        $error("current_chan mismatch: expected %0d, actual %0d",
                               want.current_chan, got.current_chan);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Ends the run if no word moves on either channel for too long. The longest quiet
    // stretch of a correct run is the long hold-off plus a short drain.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("multichannel_overwrite_fifo verification failed");
        $finish;
    end

    initial begin : stimulus
        int                  i;
        int                  phase;
        int                  n;
        int                  r;
        int                  write_pct;
        int                  focus;
        bit                  focused;
        logic [ACTION_W-1:0] act;
        logic [CHAN_W-1:0]   ch;
        logic [DEPTH_W-1:0]  depth_pick;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= '0;
        in_ch.channel   <= '0;
        in_ch.data_byte <= '0;

        // Predictor after reset: empty rings, flag and counter clear, depth at its default.
        for (i = 0; i < NUM_CH; i++) begin
            wr_ptr[i] = '0;
            rd_ptr[i] = '0;
            fill[i]   = '0;
        end
        ovf_flag       = 1'b0;
        rr_chan        = '0;
        depth_reg      = DEPTH_RESET;
        mismatch_count = 0;
        gaps_on        = 1'b1;
        hold_req       = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(DIR_ROWS); i++) begin
            if (DIR_ROWS[i].kind == ROW_DEPTH)
                write_depth(DIR_ROWS[i].depth);
            else
                send_word(DIR_ROWS[i].action, DIR_ROWS[i].channel, DIR_ROWS[i].data_byte,
                          DIR_ROWS[i].pinned, DIR_ROWS[i].result);
        end

        // Random phases. Each one sets a depth (31 and 0 first, then 1, 16 and 2, then random
        // values), a write/read balance and whether traffic is spread over all channels or
        // mostly aimed at one, so that rings fill, overflow and drain again. Every fourth
        // phase runs without idling. Phase 2 carries the long result-side hold-off.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       depth_pick = 5'd31;
                1:       depth_pick = 5'd0;
                2:       depth_pick = 5'd1;
                3:       depth_pick = 5'd16;
                4:       depth_pick = 5'd2;
                default: depth_pick = DEPTH_W'($urandom_range(0, 31));
            endcase
            write_depth(depth_pick);
            gaps_on   = (phase % 4 != 1);
            write_pct = (phase % 3 == 0) ? 65 : ((phase % 3 == 1) ? 45 : 30);
            focused   = phase[0];
            focus     = $urandom_range(0, NUM_CH - 1);
            if (phase == 2)
                hold_req = 1'b1;

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    act = ACT_UNUSED;
                else if (r < 9)
                    act = ACT_ADVANCE;
                else if (r < 9 + write_pct)
                    act = ACT_WRITE;
                else
                    act = ACT_READ;
                if (focused && $urandom_range(0, 4) != 0)
                    ch = CHAN_W'(focus);
                else
                    ch = CHAN_W'($urandom_range(0, 3));
                send_word(act, ch, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        // Drain: wait for every outstanding result, then idle on so that a stray extra word
        // from the block would still be caught.
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("multichannel_overwrite_fifo verification clean");
        else
            $display("multichannel_overwrite_fifo verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mcofifo_pkg.sv
hdl/mcofifo_if.sv
hdl/multichannel_overwrite_fifo.sv
tb/tb_top.sv
